// File: hw/rtl/sktc_pkg.sv
// sktc_pkg: request and result transaction types, operation and status codes
// for the key table. No dependencies.
`default_nettype none

package sktc_pkg;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int MAX_RES = 16;
  localparam int CNT_W   = 5;

  localparam logic [31:0] RESET_SLOT0 = 32'd5;
  localparam logic [31:0] RESET_SLOT1 = 32'd10;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic       last;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/small_key_table_crud.sv
// small_key_table_crud: fixed table of signed 32-bit slots with create, read,
// update and delete. Depends on sktc_pkg and sktc_ram.
//
//   channel   signals                  direction  handshake
//   request   start, busy, request     in         accepted when start && !busy
//   result    strobe, result           out        one cycle per strobe, no stall
//
// A request scans the slots in order through one RAM read port and one
// comparator: the whole table for create and a full read, less of it when update,
// delete or a read hitting the result cap stop early; a read of n matches
// gives n results spread over the scan. busy is high from acceptance until the
// final result. Reset clears the valid bits at once; slots never written read
// as 5, 10, then zero. The receiver cannot stall.
`default_nettype none

module small_key_table_crud #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire sktc_pkg::req_t request,
  output logic                busy,
  output logic                strobe,
  output sktc_pkg::rsp_t      result
);
  import sktc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [IW-1:0] END_ISS  = IW'(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state, state_next;
  logic [1:0]       op, op_next;
  logic [31:0]      key, key_next;
  logic [31:0]      nv, nv_next;
  logic [IW-1:0]    iss, iss_next;
  logic             cmp_vld, cmp_vld_next;
  logic [AW-1:0]    cmp_idx, cmp_idx_next;
  logic             found, found_next;
  logic [AW-1:0]    fpos, fpos_next;
  logic             efound, efound_next;
  logic [AW-1:0]    epos, epos_next;
  logic             pend_vld, pend_vld_next;
  logic [AW-1:0]    pend, pend_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [DEPTH-1:0] vld;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [31:0]      wdata;
  logic [31:0]      rdata;
  logic [31:0]      slot_val;
  logic             eq, empty, stop;
  logic             emit;
  rsp_t             emit_rsp;

  function automatic logic [31:0] reset_value(input logic [AW-1:0] idx);
    if (idx == AW'(0)) begin
      return RESET_SLOT0;
    end else if (idx == AW'(1)) begin
      return RESET_SLOT1;
    end
    return 32'd0;
  endfunction

  // slot index taken modulo 16
  function automatic logic [3:0] to_pos(input logic [AW-1:0] idx);
    logic [AW+3:0] w;
    w = {4'b0000, idx};
    return w[3:0];
  endfunction

  sktc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(iss[AW-1:0]),
    .rdata(rdata)
  );

  assign slot_val = vld[cmp_idx] ? rdata : reset_value(cmp_idx);
  assign eq       = cmp_vld && (slot_val == key);
  assign empty    = cmp_vld && (slot_val == 32'd0);
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    op_next       = op;
    key_next      = key;
    nv_next       = nv;
    iss_next      = iss;
    cmp_vld_next  = 1'b0;
    cmp_idx_next  = cmp_idx;
    found_next    = found;
    fpos_next     = fpos;
    efound_next   = efound;
    epos_next     = epos;
    pend_vld_next = pend_vld;
    pend_next     = pend;
    cnt_next      = cnt;
    we            = 1'b0;
    waddr         = fpos;
    wdata         = 32'd0;
    stop          = 1'b0;
    emit          = 1'b0;
    emit_rsp      = '{status: ST_OK, position: 4'd0, last: 1'b0};

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next       = request.req_type;
          key_next      = request.key;
          nv_next       = request.new_value;
          iss_next      = '0;
          found_next    = 1'b0;
          efound_next   = 1'b0;
          pend_vld_next = 1'b0;
          cnt_next      = '0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss != END_ISS) begin
          iss_next     = iss + IW'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = iss[AW-1:0];
        end
        case (op)
          OP_CREATE: begin
            if (eq && !found) begin
              found_next = 1'b1;
              fpos_next  = cmp_idx;
            end
            if (empty && !efound) begin
              efound_next = 1'b1;
              epos_next   = cmp_idx;
            end
          end
          OP_READ: begin
            if (eq) begin
              if (pend_vld) begin
                emit     = 1'b1;
                emit_rsp = '{status: ST_OK, position: to_pos(pend), last: 1'b0};
              end
              pend_vld_next = 1'b1;
              pend_next     = cmp_idx;
              cnt_next      = cnt + CNT_W'(1);
              if (cnt == CNT_W'(MAX_RES - 1)) begin
                stop = 1'b1;
              end
            end
          end
          default: begin
            if (eq) begin
              found_next = 1'b1;
              fpos_next  = cmp_idx;
              stop       = 1'b1;
            end
          end
        endcase
        if (cmp_vld && (cmp_idx == LAST_IDX)) begin
          stop = 1'b1;
        end
        if (stop) begin
          cmp_vld_next = 1'b0;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        case (op)
          OP_CREATE: begin
            if (found) begin
              emit_rsp = '{status: ST_PRESENT, position: to_pos(fpos), last: 1'b1};
            end else if (efound) begin
              we       = 1'b1;
              waddr    = epos;
              wdata    = key;
              emit_rsp = '{status: ST_OK, position: to_pos(epos), last: 1'b1};
            end else begin
              emit_rsp = '{status: ST_FULL, position: 4'd0, last: 1'b1};
            end
          end
          OP_READ: begin
            if (pend_vld) begin
              emit_rsp = '{status: ST_OK, position: to_pos(pend), last: 1'b1};
            end else begin
              emit_rsp = '{status: ST_MISSING, position: 4'd0, last: 1'b1};
            end
          end
          OP_UPDATE: begin
            if (found) begin
              we       = 1'b1;
              wdata    = nv;
              emit_rsp = '{status: ST_OK, position: to_pos(fpos), last: 1'b1};
            end else begin
              emit_rsp = '{status: ST_MISSING, position: 4'd0, last: 1'b1};
            end
          end
          default: begin
            if (found) begin
              we       = 1'b1;
              wdata    = 32'd0;
              emit_rsp = '{status: ST_OK, position: to_pos(fpos), last: 1'b1};
            end else begin
              emit_rsp = '{status: ST_MISSING, position: 4'd0, last: 1'b1};
            end
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmp_vld  <= 1'b0;
      strobe   <= 1'b0;
      vld      <= '0;
    end else begin
      state    <= state_next;
      cmp_vld  <= cmp_vld_next;
      strobe   <= emit;
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
    op       <= op_next;
    key      <= key_next;
    nv       <= nv_next;
    iss      <= iss_next;
    cmp_idx  <= cmp_idx_next;
    found    <= found_next;
    fpos     <= fpos_next;
    efound   <= efound_next;
    epos     <= epos_next;
    pend_vld <= pend_vld_next;
    pend     <= pend_next;
    cnt      <= cnt_next;
    result   <= emit_rsp;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sktc_ram.sv
// sktc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sktc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sktc_checker.sv
// sktc_checker: port-level assertions for small_key_table_crud, bound to it.
// Depends on sktc_pkg.
`default_nettype none

module sktc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           strobe,
  input wire sktc_pkg::rsp_t result
);
  import sktc_pkg::*;

  // an accepted transaction holds busy and gives no result in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("accept not followed by busy scan");

  // only the final result releases the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.last == !busy))
    else $error("last flag disagrees with busy");

  a_fell_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && result.last)
    else $error("busy dropped without final result");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status != ST_OK) |-> result.last)
    else $error("refusal not marked last");

  a_no_pos: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == ST_FULL || result.status == ST_MISSING)
      |-> (result.position == 4'd0))
    else $error("position set without a slot");

endmodule

bind small_key_table_crud sktc_checker u_sktc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .strobe(strobe),
  .result(result)
);

`default_nettype wire
